>>> sv/sgfi_pkg.sv
package sgfi_pkg;

    // Fixed field widths of the streaming channels and of the register port.
    localparam int CFG_W       = 7;
    localparam int IDX_W       = 15;
    localparam int VAL_W       = 32;
    localparam int RC_W        = 8;
    localparam int STAT_W      = 2;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 40;

    // Bit offsets inside the slave-side tdata.
    localparam int S_IDX_LSB   = 0;
    localparam int S_VAL_LSB   = S_IDX_LSB + IDX_W;
    localparam int S_ROW_LSB   = S_VAL_LSB + VAL_W;
    localparam int S_COL_LSB   = S_ROW_LSB + RC_W;
    localparam int S_USED_W    = S_COL_LSB + RC_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic CFG_COLS_HALF = 1'b0;
    localparam logic CFG_ROWS_HALF = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_IDX_ERR   = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE_ERR = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_FIN
    } t_state;

    // How a grid point is filled.
    typedef enum logic [1:0] {
        K_HPT,
        K_ROW_AVG,
        K_COL_AVG,
        K_QUAD
    } t_kind;

    typedef struct packed {
        logic en;
        logic we;
    } t_mem_ctl;

endpackage

>>> sv/sgfi_store.sv
module sgfi_store #(
    parameter int DEPTH = 32513,
    parameter int AW    = 15
) (
    input  logic                        i_clk,
    input  sgfi_pkg::t_mem_ctl          i_ctl,
    input  logic [AW-1:0]               i_addr,
    input  logic [sgfi_pkg::VAL_W-1:0]  i_wdata,
    output logic [sgfi_pkg::VAL_W-1:0]  o_rdata
);

    logic [sgfi_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic [sgfi_pkg::VAL_W-1:0] r_rdata;

    // Single port: a cycle either writes or reads.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/staggered_grid_fill_interpolator_top.sv
// Fill interpolator for a checkerboard-staggered grid of odd width and height.
// Requests enter on the s channel: tuser is the operation (write H sample or
// read grid point), tdata carries h_index, h_value, row and col. Every request
// gives exactly one result on the m channel: tdata carries value and status,
// tuser flags an H point.
// Grid size comes from the cols_half and rows_half registers, written by the user through the
// register port only while no request is in flight; the block does not enforce this.
// The H samples live in one single-port synchronous memory of one entry per H
// sample; its contents are undefined after reset until written.
// Steps: a request is accepted in S_IDLE, range-checked in S_CHECK, makes its memory
// reads in S_READ (none for a write or an out-of-range read, one for an H point, two
// for an edge v point, four for an interior v point) and loads its result in S_FIN.
// The block takes no new request until the previous one has left S_FIN.
// Reset clears the control state and sets both size registers to one. When the
// receiver stalls, the result waits in the output register; the block still
// takes and works on the next request and holds its result until the output
// register is free.
module staggered_grid_fill_interpolator_top #(
    parameter int MAX_HALF = 127
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Register port
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [sgfi_pkg::CFG_W-1:0]         i_cfg_data,
    // Request channel
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata from bit 0: h_index[14:0], h_value[46:15], row[54:47], col[62:55], zero
    input  logic [sgfi_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // tuser: operation
    input  logic                               i_s_tuser,
    // Result channel
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata from bit 0: value[31:0], status[33:32], zero
    output logic [sgfi_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // tuser: is_h_point
    output logic                               o_m_tuser
);

    localparam int HALF_W  = $clog2(MAX_HALF + 1);
    localparam int GW      = HALF_W + 1;
    localparam int NPTS    = (2 * MAX_HALF + 1) * (2 * MAX_HALF + 1);
    localparam int DEPTH   = (NPTS + 1) / 2;
    localparam int AW      = $clog2(DEPTH);
    localparam int LIN_W   = $clog2(NPTS);
    localparam int PW      = 2 * GW;
    localparam int CNT_W   = (PW > sgfi_pkg::IDX_W) ? PW : sgfi_pkg::IDX_W;
    localparam int RCW     = (GW > sgfi_pkg::RC_W) ? GW : sgfi_pkg::RC_W;
    localparam int CMPH_W  = (HALF_W > sgfi_pkg::CFG_W) ? HALF_W : sgfi_pkg::CFG_W;
    localparam int SUM_W   = sgfi_pkg::VAL_W + 2;

    // Size registers
    logic [HALF_W-1:0] r_cols_half, r_rows_half;
    logic [CMPH_W-1:0] cfg_ext;
    logic [HALF_W-1:0] n_cfg_val;

    always_comb begin
        cfg_ext = CMPH_W'(i_cfg_data);
        priority if (cfg_ext == '0) begin
            n_cfg_val = HALF_W'(1);
        end else if (cfg_ext > CMPH_W'(MAX_HALF)) begin
            n_cfg_val = HALF_W'(MAX_HALF);
        end else begin
            n_cfg_val = HALF_W'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_half <= HALF_W'(1);
            r_rows_half <= HALF_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sgfi_pkg::CFG_COLS_HALF: r_cols_half <= n_cfg_val;
                sgfi_pkg::CFG_ROWS_HALF: r_rows_half <= n_cfg_val;
                default: ;
            endcase
        end
    end

    // Request registers
    sgfi_pkg::t_state                r_state, n_state;
    logic                            r_is_read;
    logic [sgfi_pkg::IDX_W-1:0]      r_hidx;
    logic [sgfi_pkg::VAL_W-1:0]      r_hval;
    logic [sgfi_pkg::RC_W-1:0]       r_row, r_col;

    // Check results
    sgfi_pkg::t_kind                 r_kind;
    logic [sgfi_pkg::STAT_W-1:0]     r_status;
    logic [AW-1:0]                   r_base;
    logic [1:0]                      r_klast;
    logic [1:0]                      r_k;
    logic signed [SUM_W-1:0]         r_acc;

    // Output register
    logic                            r_m_valid;
    logic [sgfi_pkg::VAL_W-1:0]      r_m_value;
    logic [sgfi_pkg::STAT_W-1:0]     r_m_status;
    logic                            r_m_is_h;

    // Store port
    sgfi_pkg::t_mem_ctl              st_ctl;
    logic [AW-1:0]                   st_addr;
    logic [sgfi_pkg::VAL_W-1:0]      st_rdata;

    sgfi_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (st_ctl),
        .i_addr  (st_addr),
        .i_wdata (r_hval),
        .o_rdata (st_rdata)
    );

    // Range check and classification, used in the check cycle.
    logic [GW-1:0]              grid_w, grid_r;
    logic [PW-1:0]              wr_prod, h_count;
    logic                       idx_bad, rc_bad;
    logic [LIN_W-1:0]           lin;
    sgfi_pkg::t_kind            c_kind;

    always_comb begin
        grid_w  = {r_cols_half, 1'b1};
        grid_r  = {r_rows_half, 1'b1};
        wr_prod = PW'(grid_w) * PW'(grid_r);
        // w*r is odd, so (w*r+1)/2 is the half plus one.
        h_count = (wr_prod >> 1) + PW'(1);
        idx_bad = CNT_W'(r_hidx) >= CNT_W'(h_count);
        rc_bad  = (RCW'(r_row) >= RCW'(grid_r)) || (RCW'(r_col) >= RCW'(grid_w));
        lin     = LIN_W'(LIN_W'(r_row) * LIN_W'(grid_w)) + LIN_W'(r_col);
        priority if (!lin[0]) begin
            c_kind = sgfi_pkg::K_HPT;
        end else if (r_row == '0 || RCW'(r_row) == RCW'(grid_r - GW'(1))) begin
            c_kind = sgfi_pkg::K_ROW_AVG;
        end else if (r_col == '0 || RCW'(r_col) == RCW'(grid_w - GW'(1))) begin
            c_kind = sgfi_pkg::K_COL_AVG;
        end else begin
            c_kind = sgfi_pkg::K_QUAD;
        end
    end

    // Neighbor addresses. For an odd linear index L = 2a+1 and w = 2c+1 the
    // left, right, upper and lower H samples sit at a, a+1, a-c and a+c+1.
    logic [1:0]   slot;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] c_off;

    always_comb begin
        c_off = AW'(r_cols_half);
        slot  = (r_kind == sgfi_pkg::K_COL_AVG) ? (r_k + 2'd2) : r_k;
        unique case (slot)
            2'd0: rd_addr = r_base;
            2'd1: rd_addr = r_base + AW'(1);
            2'd2: rd_addr = r_base - c_off;
            2'd3: rd_addr = r_base + c_off + AW'(1);
            default: rd_addr = r_base;
        endcase
    end

    // Final sum and floor division by an arithmetic shift.
    logic signed [SUM_W-1:0] rdata_ext, fin_sum, fin_avg;
    logic                    out_free;

    always_comb begin
        rdata_ext = SUM_W'($signed(st_rdata));
        fin_sum   = r_acc + rdata_ext;
        unique case (r_kind)
            sgfi_pkg::K_HPT:     fin_avg = fin_sum;
            sgfi_pkg::K_ROW_AVG,
            sgfi_pkg::K_COL_AVG: fin_avg = fin_sum >>> 1;
            sgfi_pkg::K_QUAD:    fin_avg = fin_sum >>> 2;
            default:             fin_avg = fin_sum;
        endcase
        out_free = !r_m_valid || i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgfi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        st_ctl     = '0;
        st_addr    = rd_addr;
        unique case (r_state)
            sgfi_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = sgfi_pkg::S_CHECK;
                end
            end
            sgfi_pkg::S_CHECK: begin
                if (r_is_read && !rc_bad) begin
                    n_state = sgfi_pkg::S_READ;
                end else begin
                    n_state = sgfi_pkg::S_FIN;
                end
            end
            sgfi_pkg::S_READ: begin
                st_ctl.en = 1'b1;
                if (r_k == r_klast) begin
                    n_state = sgfi_pkg::S_FIN;
                end
            end
            sgfi_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = sgfi_pkg::S_IDLE;
                    if (!r_is_read && r_status == sgfi_pkg::ST_OK) begin
                        st_ctl.en = 1'b1;
                        st_ctl.we = 1'b1;
                        st_addr   = AW'(r_hidx);
                    end
                end
            end
            default: n_state = sgfi_pkg::S_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == sgfi_pkg::S_IDLE && i_s_tvalid) begin
            r_is_read <= i_s_tuser == sgfi_pkg::OP_READ;
            r_hidx    <= i_s_tdata[sgfi_pkg::S_IDX_LSB +: sgfi_pkg::IDX_W];
            r_hval    <= i_s_tdata[sgfi_pkg::S_VAL_LSB +: sgfi_pkg::VAL_W];
            r_row     <= i_s_tdata[sgfi_pkg::S_ROW_LSB +: sgfi_pkg::RC_W];
            r_col     <= i_s_tdata[sgfi_pkg::S_COL_LSB +: sgfi_pkg::RC_W];
        end
        if (r_state == sgfi_pkg::S_CHECK) begin
            r_kind  <= c_kind;
            r_base  <= AW'(lin >> 1);
            r_k     <= 2'd0;
            r_acc   <= '0;
            unique case (c_kind)
                sgfi_pkg::K_HPT:     r_klast <= 2'd0;
                sgfi_pkg::K_ROW_AVG,
                sgfi_pkg::K_COL_AVG: r_klast <= 2'd1;
                sgfi_pkg::K_QUAD:    r_klast <= 2'd3;
                default:             r_klast <= 2'd0;
            endcase
            priority if (r_is_read) begin
                r_status <= rc_bad ? sgfi_pkg::ST_RANGE_ERR : sgfi_pkg::ST_OK;
            end else begin
                r_status <= idx_bad ? sgfi_pkg::ST_IDX_ERR : sgfi_pkg::ST_OK;
            end
        end
        if (r_state == sgfi_pkg::S_READ) begin
            r_k <= r_k + 2'd1;
            // Read data comes back in the cycle after its address.
            if (r_k != 2'd0) begin
                r_acc <= fin_sum;
            end
        end
    end

    // Output register
    logic read_ok;
    assign read_ok = r_is_read && r_status == sgfi_pkg::ST_OK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == sgfi_pkg::S_FIN && out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sgfi_pkg::S_FIN && out_free) begin
            r_m_value  <= read_ok ? sgfi_pkg::VAL_W'(fin_avg) : '0;
            r_m_status <= r_status;
            r_m_is_h   <= read_ok && r_kind == sgfi_pkg::K_HPT;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(sgfi_pkg::M_TDATA_W - sgfi_pkg::VAL_W - sgfi_pkg::STAT_W){1'b0}},
                         r_m_status, r_m_value};
    assign o_m_tuser  = r_m_is_h;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[33:32] != sgfi_pkg::ST_OK
            |-> o_m_tdata[31:0] == '0 && !o_m_tuser)
        else $error("error result carries a value or H flag");

    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sgfi_pkg::S_READ |-> r_k <= r_klast)
        else $error("read sequencer ran past its last neighbor");

    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_state == sgfi_pkg::S_CHECK)
        else $error("accepted request did not enter the check cycle");

    a_write_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_ctl.we |-> st_ctl.en && !r_is_read && r_status == sgfi_pkg::ST_OK && out_free)
        else $error("store written for a request that must not write");

endmodule

>>> verif/tb_top.sv
module tb_top;

    localparam int GRID_MAX_HALF = 127;
    localparam int IDLE_PCT      = 20;
    localparam int PHASE_ITEMS   = 290;

    typedef struct {
        logic [sgfi_pkg::VAL_W-1:0]  value;
        logic [sgfi_pkg::STAT_W-1:0] status;
        logic                        is_h;
    } t_fill_result;

    // Tracks the grid size and the H samples written so far, and predicts the
    // result of every accepted request.
    class t_fill_checker;
        int unsigned  cols_half = 1;
        int unsigned  rows_half = 1;
        int           samples[int];
        t_fill_result due_fills[$];
        int unsigned  errors = 0;

        function int unsigned width();
            return 2 * cols_half + 1;
        endfunction

        function int unsigned height();
            return 2 * rows_half + 1;
        endfunction

        function int unsigned h_count();
            return (width() * height() + 1) / 2;
        endfunction

        function bit has_sample(int unsigned idx);
            return samples.exists(idx);
        endfunction

        function int unsigned outstanding();
            return due_fills.size();
        endfunction

        function int unsigned clamp_half(logic [sgfi_pkg::CFG_W-1:0] data);
            int unsigned v;
            v = 32'(data);
            if (v < 1) v = 1;
            if (v > GRID_MAX_HALF) v = GRID_MAX_HALF;
            return v;
        endfunction

        function void set_size(logic [sgfi_pkg::CFG_W-1:0] c,
                               logic [sgfi_pkg::CFG_W-1:0] r);
            cols_half = clamp_half(c);
            rows_half = clamp_half(r);
        endfunction

        // H indices whose samples make up the filled value at (row, col).
        function void h_sources(int unsigned row, int unsigned col,
                                output int unsigned src[$]);
            int unsigned w;
            int unsigned lin;
            w = width();
            lin = row * w + col;
            src.delete();
            if (lin % 2 == 0) begin
                src.push_back(lin / 2);
            end else if (row == 0 || row == height() - 1) begin
                src.push_back((lin - 1) / 2);
                src.push_back((lin + 1) / 2);
            end else if (col == 0 || col == w - 1) begin
                src.push_back((lin - w) / 2);
                src.push_back((lin + w) / 2);
            end else begin
                src.push_back((lin - 1) / 2);
                src.push_back((lin + 1) / 2);
                src.push_back((lin - w) / 2);
                src.push_back((lin + w) / 2);
            end
        endfunction

        function void note_request(logic op, logic [sgfi_pkg::IDX_W-1:0] idx,
                                   logic [sgfi_pkg::VAL_W-1:0] val,
                                   logic [sgfi_pkg::RC_W-1:0] row,
                                   logic [sgfi_pkg::RC_W-1:0] col);
            t_fill_result res;
            int unsigned  src[$];
            longint       acc;
            res.value  = '0;
            res.status = sgfi_pkg::ST_OK;
            res.is_h   = 1'b0;
            if (op == sgfi_pkg::OP_WRITE) begin
                if (idx >= h_count()) begin
                    res.status = sgfi_pkg::ST_IDX_ERR;
                end else begin
                    samples[idx] = val;
                end
            end else if (row >= height() || col >= width()) begin
                res.status = sgfi_pkg::ST_RANGE_ERR;
            end else begin
                h_sources(row, col, src);
                acc = 0;
                foreach (src[i]) acc += longint'(samples[src[i]]);
                // The sum is exact; the arithmetic shift floors it.
                if (src.size() == 1) begin
                    res.is_h = 1'b1;
                end else if (src.size() == 2) begin
                    acc = acc >>> 1;
                end else begin
                    acc = acc >>> 2;
                end
                res.value = acc[sgfi_pkg::VAL_W-1:0];
            end
            due_fills.push_back(res);
        endfunction

        function void check_result(logic [sgfi_pkg::VAL_W-1:0] value,
                                   logic [sgfi_pkg::STAT_W-1:0] status,
                                   logic is_h);
            t_fill_result want;
            if (due_fills.size() == 0) begin
                $error("unexpected result: value %h status %0d is_h_point %0b",
                       value, status, is_h);
                errors++;
                return;
            end
            want = due_fills.pop_front();
            if (value !== want.value) begin
                $error("value: expected %h, got %h", want.value, value);
                errors++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (is_h !== want.is_h) begin
                $error("is_h_point: expected %0b, got %0b", want.is_h, is_h);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic                           i_cfg_idx;
    logic [sgfi_pkg::CFG_W-1:0]     i_cfg_data;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [sgfi_pkg::S_TDATA_W-1:0] i_s_tdata;
    logic                           i_s_tuser;
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [sgfi_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic                           o_m_tuser;

    t_fill_checker sb = new();
    bit            steady = 1'b0;
    int unsigned   sent = 0;

    staggered_grid_fill_interpolator_top #(
        .MAX_HALF(GRID_MAX_HALF)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [sgfi_pkg::VAL_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Leaves tvalid high on return so that back-to-back requests need no gap.
    task automatic send_request(logic op, logic [sgfi_pkg::IDX_W-1:0] idx,
                                logic [sgfi_pkg::VAL_W-1:0] val,
                                logic [sgfi_pkg::RC_W-1:0] row,
                                logic [sgfi_pkg::RC_W-1:0] col);
        logic [sgfi_pkg::S_TDATA_W-1:0] data;
        data = '0;
        data[sgfi_pkg::S_IDX_LSB +: sgfi_pkg::IDX_W] = idx;
        data[sgfi_pkg::S_VAL_LSB +: sgfi_pkg::VAL_W] = val;
        data[sgfi_pkg::S_ROW_LSB +: sgfi_pkg::RC_W]  = row;
        data[sgfi_pkg::S_COL_LSB +: sgfi_pkg::RC_W]  = col;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(op, idx, val, row, col);
        sent++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic set_size(logic [sgfi_pkg::CFG_W-1:0] c, logic [sgfi_pkg::CFG_W-1:0] r);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sgfi_pkg::CFG_COLS_HALF;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_idx  <= sgfi_pkg::CFG_ROWS_HALF;
        i_cfg_data <= r;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_size(c, r);
    endtask

    // Reads an in-grid point, first writing any sample it depends on that the
    // store does not hold yet.
    task automatic read_point();
        int unsigned row;
        int unsigned col;
        int unsigned src[$];
        row = $urandom_range(0, sb.height() - 1);
        col = $urandom_range(0, sb.width() - 1);
        if ($urandom_range(0, 3) == 0) row = $urandom_range(0, 1) ? 0 : sb.height() - 1;
        if ($urandom_range(0, 3) == 0) col = $urandom_range(0, 1) ? 0 : sb.width() - 1;
        sb.h_sources(row, col, src);
        foreach (src[i]) begin
            if (!sb.has_sample(src[i])) begin
                send_request(sgfi_pkg::OP_WRITE, sgfi_pkg::IDX_W'(src[i]), rand_sample(),
                             sgfi_pkg::RC_W'($urandom_range(0, 255)),
                             sgfi_pkg::RC_W'($urandom_range(0, 255)));
            end
        end
        send_request(sgfi_pkg::OP_READ, sgfi_pkg::IDX_W'($urandom_range(0, 32767)), $urandom,
                     sgfi_pkg::RC_W'(row), sgfi_pkg::RC_W'(col));
    endtask

    task automatic read_off_grid();
        int unsigned row;
        int unsigned col;
        if ($urandom_range(0, 1)) begin
            row = $urandom_range(sb.height(), 255);
            col = $urandom_range(0, 255);
        end else begin
            row = $urandom_range(0, 255);
            col = $urandom_range(sb.width(), 255);
        end
        send_request(sgfi_pkg::OP_READ, sgfi_pkg::IDX_W'($urandom_range(0, 32767)), $urandom,
                     sgfi_pkg::RC_W'(row), sgfi_pkg::RC_W'(col));
    endtask

    // Result side: check on every handshake, then choose the next tready.
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                sb.check_result(o_m_tdata[sgfi_pkg::VAL_W-1:0],
                                o_m_tdata[sgfi_pkg::VAL_W +: sgfi_pkg::STAT_W], o_m_tuser);
            end
            i_m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        int unsigned goal;
        int unsigned pick;
        bit          paused;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= sgfi_pkg::CFG_COLS_HALF;
        i_cfg_data <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= sgfi_pkg::OP_WRITE;
        paused = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 grid after reset: opposite extremes side by side so that every
        // edge average has an odd negative sum and must round down.
        send_request(sgfi_pkg::OP_WRITE, 15'd0, 32'h7FFF_FFFF, 8'd0, 8'd0);
        send_request(sgfi_pkg::OP_WRITE, 15'd1, 32'h8000_0000, 8'd0, 8'd0);
        send_request(sgfi_pkg::OP_WRITE, 15'd2, 32'hFFFF_FFFF, 8'd0, 8'd0);
        send_request(sgfi_pkg::OP_WRITE, 15'd3, 32'h8000_0000, 8'd0, 8'd0);
        send_request(sgfi_pkg::OP_WRITE, 15'd4, 32'h7FFF_FFFF, 8'd0, 8'd0);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                send_request(sgfi_pkg::OP_READ, 15'd0, 32'd0,
                             sgfi_pkg::RC_W'(r), sgfi_pkg::RC_W'(c));
            end
        end
        send_request(sgfi_pkg::OP_WRITE, 15'd5, 32'h1234_5678, 8'd0, 8'd0);
        send_request(sgfi_pkg::OP_WRITE, 15'd32767, 32'hFFFF_FFFF, 8'd255, 8'd255);
        send_request(sgfi_pkg::OP_READ, 15'd0, 32'd0, 8'd3, 8'd0);
        send_request(sgfi_pkg::OP_READ, 15'd0, 32'd0, 8'd0, 8'd3);
        send_request(sgfi_pkg::OP_READ, 15'd32767, 32'hFFFF_FFFF, 8'd255, 8'd255);

        // 5x5 grid: interior point whose four neighbours are all most negative.
        set_size(7'd2, 7'd2);
        send_request(sgfi_pkg::OP_WRITE, 15'd1, 32'h8000_0000, 8'd0, 8'd0);
        send_request(sgfi_pkg::OP_WRITE, 15'd3, 32'h8000_0000, 8'd0, 8'd0);
        send_request(sgfi_pkg::OP_WRITE, 15'd4, 32'h8000_0000, 8'd0, 8'd0);
        send_request(sgfi_pkg::OP_WRITE, 15'd6, 32'h8000_0000, 8'd0, 8'd0);
        send_request(sgfi_pkg::OP_READ, 15'd0, 32'd0, 8'd1, 8'd2);

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: set_size(7'd127, 7'd127);
                1: set_size(7'd0, 7'd127);
                2: set_size(7'd127, 7'd0);
                3: set_size(7'd2, 7'd3);
                6: set_size(7'd1, 7'd1);
                default: set_size(sgfi_pkg::CFG_W'($urandom_range(1, 12)),
                                  sgfi_pkg::CFG_W'($urandom_range(1, 12)));
            endcase
            steady = (p == 3);
            goal = sent + PHASE_ITEMS;
            while (sent < goal) begin
                // In the first phase only, hold off once mid-phase until every result is back.
                if (p == 0 && !paused && sent + 190 >= goal) begin
                    drain();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    read_point();
                end else if (pick < 85) begin
                    send_request(sgfi_pkg::OP_WRITE,
                                 sgfi_pkg::IDX_W'($urandom_range(0, sb.h_count() - 1)),
                                 rand_sample(),
                                 sgfi_pkg::RC_W'($urandom_range(0, 255)),
                                 sgfi_pkg::RC_W'($urandom_range(0, 255)));
                end else if (pick < 92) begin
                    send_request(sgfi_pkg::OP_WRITE,
                                 sgfi_pkg::IDX_W'($urandom_range(sb.h_count(), 32767)),
                                 $urandom,
                                 sgfi_pkg::RC_W'($urandom_range(0, 255)),
                                 sgfi_pkg::RC_W'($urandom_range(0, 255)));
                end else begin
                    read_off_grid();
                end
            end
        end
        steady = 1'b0;

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
